>>> rtl/core/wrf_pkg.sv
// shared types, constants and fixed-point helpers for the wall repulsion core
package wrf_pkg;

	typedef logic signed [31:0] fx_t;
	typedef logic signed [17:0] dir_t;

	typedef enum logic [2:0] {
		ZONE_NONE    = 3'd0,
		ZONE_TAPER   = 3'd1,
		ZONE_INVERSE = 3'd2,
		ZONE_BLEND   = 3'd3,
		ZONE_CLAMP   = 3'd4
	} zone_t;

	typedef enum logic [1:0] {
		REG_NU_GAIN      = 2'd0,
		REG_INTERP_WIDTH = 2'd1,
		REG_CUTOFF       = 2'd2,
		REG_MAX_FORCE    = 2'd3
	} reg_idx_t;

	localparam fx_t SAT_MAX = 32'sh7FFF_FFFF;
	localparam fx_t SAT_MIN = 32'sh8000_0000;

	// quotient bits resolved by the divider, and its register depth
	localparam int QBITS   = 33;
	localparam int DIV_LAT = QBITS + 1;

	typedef struct packed {
		zone_t zone;
		dir_t  ex;
		dir_t  ey;
		fx_t   dv;
		fx_t   tden;
	} side1_t;

	typedef struct packed {
		zone_t zone;
		dir_t  ex;
		dir_t  ey;
		fx_t   tden;
		fx_t   tc;
		fx_t   f;
	} side2_t;

	typedef struct packed {
		zone_t zone;
		fx_t   fy;
		fx_t   fx;
	} res_t;

	function automatic logic signed [33:0] ext34(input fx_t v);
		return {{2{v[31]}}, v};
	endfunction

	function automatic fx_t sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			return SAT_MAX;
		if (v < -34'sd2147483648)
			return SAT_MIN;
		return v[31:0];
	endfunction

	function automatic fx_t neg_sat(input fx_t v);
		return (v == SAT_MIN) ? SAT_MAX : -v;
	endfunction

	function automatic logic [31:0] mag32(input fx_t v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

>>> rtl/core/wrf_div.sv
// pipelined rounding fixed-point divider, one quotient bit per stage, saturating
module wrf_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           en,
	input  wrf_pkg::fx_t   num,
	input  wrf_pkg::fx_t   den,
	output wrf_pkg::fx_t   quo
);
	import wrf_pkg::*;

	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = (NW > 32 + QBITS - 1) ? NW : 32 + QBITS - 1;
	localparam int OW = (NW > 32 + QBITS) ? NW : 32 + QBITS;

	logic [31:0]    ma;
	logic [31:0]    mb;
	logic [NW-1:0]  nn;
	logic           ovf0;

	logic [NW-1:0]    rem_s [QBITS];
	logic [31:0]      mb_s  [QBITS];
	logic [QBITS-1:0] quo_s [QBITS+1];
	logic             neg_s [QBITS+1];
	logic             ovf_s [QBITS+1];
	logic             zro_s [QBITS+1];

	logic [CW-1:0]    sub_c [1:QBITS];
	logic             ge_c  [1:QBITS];
	logic [QBITS-1:0] q;

	always_comb begin
		ma   = mag32(num);
		mb   = mag32(den);
		nn   = {ma, {FRAC_BITS{1'b0}}} + NW'(mb >> 1);
		ovf0 = OW'(nn) >= (OW'(mb) << QBITS);
	end

	always_comb begin
		for (int j = 1; j <= QBITS; j++) begin
			sub_c[j] = CW'(mb_s[j-1]) << (QBITS - j);
			ge_c[j]  = CW'(rem_s[j-1]) >= sub_c[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= nn;
			mb_s[0]  <= mb;
			quo_s[0] <= '0;
			neg_s[0] <= num[31] ^ den[31];
			ovf_s[0] <= ovf0;
			zro_s[0] <= (ma == 32'd0);
			for (int j = 1; j < QBITS; j++) begin
				rem_s[j] <= ge_c[j] ? NW'(CW'(rem_s[j-1]) - sub_c[j]) : rem_s[j-1];
				mb_s[j]  <= mb_s[j-1];
			end
			for (int j = 1; j <= QBITS; j++) begin
				quo_s[j] <= {quo_s[j-1][QBITS-2:0], ge_c[j]};
				neg_s[j] <= neg_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				zro_s[j] <= zro_s[j-1];
			end
		end
	end

	always_comb begin
		q = quo_s[QBITS];
		if (zro_s[QBITS])
			quo = '0;
		else if (ovf_s[QBITS] || q[QBITS-1] ||
			(q[31] && (!neg_s[QBITS] || q[30:0] != 31'd0)))
			quo = neg_s[QBITS] ? SAT_MIN : SAT_MAX;
		else
			quo = neg_s[QBITS] ? -$signed(q[31:0]) : $signed(q[31:0]);
	end

endmodule

>>> rtl/core/wrf_delay.sv
// valid-tagged delay line with stall enable for sideband data
module wrf_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	output logic [W-1:0] out_data
);

	logic [DEPTH-1:0] vld_s;
	logic [W-1:0]     dat_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < DEPTH; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s[0] <= in_data;
			for (int i = 1; i < DEPTH; i++)
				dat_s[i] <= dat_s[i-1];
		end
	end

	assign out_valid = vld_s[DEPTH-1];
	assign out_data  = dat_s[DEPTH-1];

endmodule

>>> rtl/core/wall_repulsion_force_interp_core.sv
// top level of the wall repulsion force core with zone interpolation
//
// One pedestrian-wall pair enters on the s_ stream as a single transfer and
// one force result leaves on the m_ stream, in order, one for one.
// Registers are written over the cfg channel (cfg_ready is always high) and
// should only change while no item is in flight.
// Throughput: one item per clock while the skid register is empty. The path
// runs through two dependent 34-stage bit-per-clock dividers (force
// scale, then its slope) plus the multiply stages around them.
// The whole pipeline advances on one enable. When the receiver holds
// m_tready low, the result in the output register waits, the next result
// lands in a one-entry skid register, and only then does s_tready drop; it
// rises again the cycle after the skid register drains.
// Reset clears all valid bits and the skid state and loads the register
// defaults; there is no clearing pass, s_tready is high straight after reset.
module wall_repulsion_force_interp_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// desired_speed, k_factor, dir_x, dir_y, normal_speed, center_distance,
	// ellipse_radius
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// force_x, force_y
	output logic [63:0]  m_tdata,
	// zone
	output logic [2:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data
);
	import wrf_pkg::*;

	localparam logic [30:0] NU_RST   = 31'((64'(18350) << FRAC_BITS) >> 16);
	localparam logic [30:0] W_RST    = 31'((64'(6554) << FRAC_BITS) >> 16);
	localparam logic [30:0] CUT_RST  = 31'((64'(131072) << FRAC_BITS) >> 16);
	localparam logic [30:0] FMAX_RST = 31'((64'(196608) << FRAC_BITS) >> 16);
	localparam logic [63:0] RND      = 64'd1 << (FRAC_BITS - 1);
	localparam fx_t         HALF     = fx_t'(64'd1 << (FRAC_BITS - 1));
	localparam fx_t         ONE      = fx_t'(64'd1 << FRAC_BITS);

	function automatic fx_t fmul(input fx_t a, input fx_t b);
		logic [63:0] pr;
		logic [63:0] m;
		pr = 64'(mag32(a)) * 64'(mag32(b));
		m  = (pr + RND) >> FRAC_BITS;
		if (a[31] != b[31]) begin
			if (m > 64'd2147483648)
				return SAT_MIN;
			return fx_t'(32'd0 - m[31:0]);
		end
		if (m > 64'd2147483647)
			return SAT_MAX;
		return fx_t'(m[31:0]);
	endfunction

	function automatic fx_t dext(input dir_t v);
		return {{14{v[17]}}, v};
	endfunction

	// configuration
	logic [30:0] nu_q, w_q, cut_q, fmax_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nu_q   <= NU_RST;
			w_q    <= W_RST;
			cut_q  <= CUT_RST;
			fmax_q <= FMAX_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_NU_GAIN:      nu_q   <= cfg_data;
				REG_INTERP_WIDTH: w_q    <= cfg_data;
				REG_CUTOFF:       cut_q  <= cfg_data;
				REG_MAX_FORCE:    fmax_q <= cfg_data;
			endcase
		end
	end

	fx_t cut_c, smax_c, left_c, right_c;

	always_comb begin
		cut_c   = {1'b0, cut_q};
		smax_c  = sat32(ext34(HALF) - ext34({1'b0, w_q}));
		left_c  = sat32(ext34(HALF) + ext34({1'b0, w_q}));
		right_c = sat32(ext34(cut_c) - ext34({1'b0, w_q}));
	end

	// flow control
	logic en;
	logic sk_valid_q, out_valid_q;
	res_t sk_q, out_q, res_c;

	assign en       = !sk_valid_q;
	assign s_tready = en;

	// stage 1: nu*v0, effective distance
	logic        v_s1;
	fx_t         nv_s1, vn_s1, deff_s1;
	logic [30:0] r_s1, k_s1;
	dir_t        ex_s1, ey_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			nv_s1   <= fmul({1'b0, nu_q}, {1'b0, s_tdata[30:0]});
			k_s1    <= s_tdata[61:31];
			ex_s1   <= s_tdata[79:62];
			ey_s1   <= s_tdata[97:80];
			vn_s1   <= s_tdata[129:98];
			deff_s1 <= $signed({1'b0, s_tdata[160:130]}) - $signed({1'b0, s_tdata[191:161]});
			r_s1    <= s_tdata[191:161];
		end
	end

	// stage 2: speed sum, zone decision
	logic        v_s2;
	fx_t         s_s2, deff_s2;
	zone_t       zone_s2;
	logic [30:0] k_s2;
	dir_t        ex_s2, ey_s2;
	fx_t         smaxr_c;
	zone_t       zone_c;

	always_comb begin
		smaxr_c = sat32(ext34(smax_c) + ext34({1'b0, r_s1}));
		if (deff_s1 >= cut_c)
			zone_c = ZONE_NONE;
		else if (deff_s1 <= smaxr_c)
			zone_c = ZONE_CLAMP;
		else if (deff_s1 > right_c)
			zone_c = ZONE_TAPER;
		else if (deff_s1 >= left_c)
			zone_c = ZONE_INVERSE;
		else
			zone_c = ZONE_BLEND;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2    <= sat32(ext34(nv_s1) + ext34(vn_s1));
			deff_s2 <= deff_s1;
			zone_s2 <= zone_c;
			k_s2    <= k_s1;
			ex_s2   <= ex_s1;
			ey_s2   <= ey_s1;
		end
	end

	// stage 3: square, divider operands
	logic        v_s3;
	fx_t         ssq_s3, tnum_s3, tden_s3, dv_s3;
	zone_t       zone_s3;
	logic [30:0] k_s3;
	dir_t        ex_s3, ey_s3;
	fx_t         x1_c, x2_c, dv_c;

	always_comb begin
		case (zone_s2)
			ZONE_TAPER: begin
				x1_c = right_c;
				x2_c = cut_c;
				dv_c = right_c;
			end
			ZONE_INVERSE: begin
				x1_c = smax_c;
				x2_c = left_c;
				dv_c = deff_s2[31] ? neg_sat(deff_s2) : deff_s2;
			end
			default: begin
				x1_c = smax_c;
				x2_c = left_c;
				dv_c = left_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ssq_s3  <= fmul(s_s2, s_s2);
			tnum_s3 <= sat32(ext34(deff_s2) - ext34(x1_c));
			tden_s3 <= sat32(ext34(x2_c) - ext34(x1_c));
			dv_s3   <= dv_c;
			zone_s3 <= zone_s2;
			k_s3    <= k_s2;
			ex_s3   <= ex_s2;
			ey_s3   <= ey_s2;
		end
	end

	// stage 4: numerator
	logic  v_s4;
	fx_t   nom_s4, tnum_s4, tden_s4, dv_s4;
	zone_t zone_s4;
	dir_t  ex_s4, ey_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nom_s4  <= fmul(ssq_s3, {1'b0, k_s3});
			tnum_s4 <= tnum_s3;
			tden_s4 <= tden_s3;
			dv_s4   <= dv_s3;
			zone_s4 <= zone_s3;
			ex_s4   <= ex_s3;
			ey_s4   <= ey_s3;
		end
	end

	// first divider pair: nom/divisor and hermite position
	fx_t    q1_c, t_c;
	logic   d1_valid;
	side1_t d1_in, d1_out;

	assign d1_in = '{zone: zone_s4, ex: ex_s4, ey: ey_s4, dv: dv_s4, tden: tden_s4};

	wrf_div #(.FRAC_BITS(FRAC_BITS)) u_div_nom (
		.clk (clk),
		.en  (en),
		.num (nom_s4),
		.den (dv_s4),
		.quo (q1_c)
	);

	wrf_div #(.FRAC_BITS(FRAC_BITS)) u_div_pos (
		.clk (clk),
		.en  (en),
		.num (tnum_s4),
		.den (tden_s4),
		.quo (t_c)
	);

	wrf_delay #(.W($bits(side1_t)), .DEPTH(DIV_LAT)) u_dly1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_data   (d1_in),
		.out_valid (d1_valid),
		.out_data  (d1_out)
	);

	// stage 5: force scale, clamped position
	logic  v_s5;
	fx_t   f_s5, tc_s5, dv_s5, tden_s5;
	zone_t zone_s5;
	dir_t  ex_s5, ey_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s5    <= neg_sat(q1_c);
			if (t_c[31])
				tc_s5 <= '0;
			else if (t_c > ONE)
				tc_s5 <= ONE;
			else
				tc_s5 <= t_c;
			dv_s5   <= d1_out.dv;
			tden_s5 <= d1_out.tden;
			zone_s5 <= d1_out.zone;
			ex_s5   <= d1_out.ex;
			ey_s5   <= d1_out.ey;
		end
	end

	// second divider: slope
	fx_t    q2_c;
	logic   d2_valid;
	side2_t d2_in, d2_out;

	assign d2_in = '{zone: zone_s5, ex: ex_s5, ey: ey_s5, tden: tden_s5, tc: tc_s5, f: f_s5};

	wrf_div #(.FRAC_BITS(FRAC_BITS)) u_div_slope (
		.clk (clk),
		.en  (en),
		.num (f_s5),
		.den (dv_s5),
		.quo (q2_c)
	);

	wrf_delay #(.W($bits(side2_t)), .DEPTH(DIV_LAT)) u_dly2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_data   (d2_in),
		.out_valid (d2_valid),
		.out_data  (d2_out)
	);

	// stage 6: slope, t squared
	logic  v_s6;
	fx_t   f1_s6, t2_s6, tc_s6, f_s6, tden_s6;
	zone_t zone_s6;
	dir_t  ex_s6, ey_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s6   <= neg_sat(q2_c);
			t2_s6   <= fmul(d2_out.tc, d2_out.tc);
			tc_s6   <= d2_out.tc;
			f_s6    <= d2_out.f;
			tden_s6 <= d2_out.tden;
			zone_s6 <= d2_out.zone;
			ex_s6   <= d2_out.ex;
			ey_s6   <= d2_out.ey;
		end
	end

	// stage 7: t cubed, start value
	logic  v_s7;
	fx_t   t3_s7, t2_s7, tc_s7, y1_s7, f_s7, f1_s7, tden_s7;
	zone_t zone_s7;
	dir_t  ex_s7, ey_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			t3_s7   <= fmul(t2_s6, tc_s6);
			y1_s7   <= (zone_s6 == ZONE_BLEND) ? fmul({1'b0, fmax_q}, f_s6) : f_s6;
			t2_s7   <= t2_s6;
			tc_s7   <= tc_s6;
			f_s7    <= f_s6;
			f1_s7   <= f1_s6;
			tden_s7 <= tden_s6;
			zone_s7 <= zone_s6;
			ex_s7   <= ex_s6;
			ey_s7   <= ey_s6;
		end
	end

	// stage 8: hermite basis
	logic  v_s8;
	fx_t   h00_s8, hs_s8, h01_s8, y1_s8, f_s8, f1_s8, tden_s8;
	zone_t zone_s8;
	dir_t  ex_s8, ey_s8;
	fx_t   h10_c, h11_c;

	always_comb begin
		h10_c = sat32(ext34(t3_s7) - ext34(t2_s7) - ext34(t2_s7) + ext34(tc_s7));
		h11_c = sat32(ext34(t3_s7) - ext34(t2_s7));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h00_s8  <= sat32(ext34(t3_s7) + ext34(t3_s7) - ext34(t2_s7) - ext34(t2_s7)
				- ext34(t2_s7) + ext34(ONE));
			h01_s8  <= sat32(ext34(t2_s7) + ext34(t2_s7) + ext34(t2_s7)
				- ext34(t3_s7) - ext34(t3_s7));
			hs_s8   <= (zone_s7 == ZONE_TAPER) ? h10_c : h11_c;
			y1_s8   <= y1_s7;
			f_s8    <= f_s7;
			f1_s8   <= f1_s7;
			tden_s8 <= tden_s7;
			zone_s8 <= zone_s7;
			ex_s8   <= ex_s7;
			ey_s8   <= ey_s7;
		end
	end

	// stage 9: basis products
	logic  v_s9;
	fx_t   a_s9, b_s9, hb_s9, f_s9, f1_s9;
	zone_t zone_s9;
	dir_t  ex_s9, ey_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s9    <= fmul(h00_s8, y1_s8);
			b_s9    <= (zone_s8 == ZONE_TAPER) ? '0 : fmul(h01_s8, f_s8);
			hb_s9   <= fmul(hs_s8, tden_s8);
			f_s9    <= f_s8;
			f1_s9   <= f1_s8;
			zone_s9 <= zone_s8;
			ex_s9   <= ex_s8;
			ey_s9   <= ey_s8;
		end
	end

	// stage 10: slope term, partial sum
	logic  v_s10;
	fx_t   c_s10, ab_s10, f_s10;
	zone_t zone_s10;
	dir_t  ex_s10, ey_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s10    <= fmul(hb_s9, f1_s9);
			ab_s10   <= sat32(ext34(a_s9) + ext34(b_s9));
			f_s10    <= f_s9;
			zone_s10 <= zone_s9;
			ex_s10   <= ex_s9;
			ey_s10   <= ey_s9;
		end
	end

	// stage 11: force scale per zone
	logic  v_s11;
	fx_t   p_s11;
	zone_t zone_s11;
	dir_t  ex_s11, ey_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			case (zone_s10)
				ZONE_NONE:    p_s11 <= '0;
				ZONE_CLAMP:   p_s11 <= -$signed({1'b0, fmax_q});
				ZONE_INVERSE: p_s11 <= f_s10;
				default:      p_s11 <= sat32(ext34(ab_s10) + ext34(c_s10));
			endcase
			zone_s11 <= zone_s10;
			ex_s11   <= ex_s10;
			ey_s11   <= ey_s10;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= d1_valid;
			v_s6  <= d2_valid;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// output register and skid
	logic lv;

	assign lv = v_s11 && en;

	always_comb begin
		res_c.fx   = fmul(dext(ex_s11), p_s11);
		res_c.fy   = fmul(dext(ey_s11), p_s11);
		res_c.zone = zone_s11;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (out_valid_q && !m_tready) begin
			if (lv)
				sk_valid_q <= 1'b1;
		end else if (sk_valid_q) begin
			out_valid_q <= 1'b1;
			sk_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= lv;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !m_tready) begin
			if (lv)
				sk_q <= res_c;
		end else begin
			out_q <= sk_valid_q ? sk_q : res_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.fy, out_q.fx};
	assign m_tuser  = out_q.zone;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(sk_valid_q && m_tready) |=> !sk_valid_q)
		else $error("skid register did not drain after output transfer");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ZONE_NONE) |-> (m_tdata == 64'd0))
		else $error("nonzero force outside cutoff");
`endif

endmodule

>>> test/tb_wall_repulsion_force_interp_core.sv
// testbench for the wall repulsion force core: streams pedestrian-wall pairs, checks forces and zones
`timescale 1ns / 1ps

module tb_wall_repulsion_force_interp_core;
	import wrf_pkg::*;

	localparam int FB = 16;
	localparam int IDLE_WAIT = 100;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 150;

	typedef struct {
		logic [30:0] v0;
		logic [30:0] k;
		dir_t        ex;
		dir_t        ey;
		fx_t         vn;
		logic [30:0] d;
		logic [30:0] r;
	} pair_t;

	typedef struct {
		fx_t   fx;
		fx_t   fy;
		zone_t zone;
	} force_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [30:0]  cfg_data;

	longint nu_q, width_q, cut_q, fmax_q;
	pair_t  pending[$];
	force_t expected_forces[$];
	int     errors, n_in, n_out, n_cfg, idle_cycles;
	int     burst_left, gap_left, hold_left;
	bit     long_hold_done;
	int     zone_seen[5];

	wall_repulsion_force_interp_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned absval(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint unsigned m;
		longint q;
		m = (absval(a) * absval(b) + (64'd1 << (FB - 1))) >> FB;
		q = longint'(m);
		return clip32(((a < 0) != (b < 0)) ? -q : q);
	endfunction

	function automatic longint qdiv(longint a, longint b);
		longint unsigned ma, mb;
		longint q;
		if (b == 0) return a > 0 ? 64'sd2147483647 : (a < 0 ? -64'sd2147483648 : 0);
		ma = absval(a);
		mb = absval(b);
		q = longint'(((ma << FB) + mb / 2) / mb);
		return clip32(((a < 0) != (b < 0)) ? -q : q);
	endfunction

	function automatic longint spline(longint x, longint x1, longint x2,
			longint y1, longint y2, longint s1, longint s2);
		longint one, h, t, t2, t3, h00, h10, h01, h11, acc;
		one = 64'sd1 << FB;
		h = clip32(x2 - x1);
		t = qdiv(clip32(x - x1), h);
		if (t < 0) t = 0;
		if (t > one) t = one;
		t2 = qmul(t, t);
		t3 = qmul(t2, t);
		h00 = clip32(2 * t3 - 3 * t2 + one);
		h10 = clip32(t3 - 2 * t2 + t);
		h01 = clip32(3 * t2 - 2 * t3);
		h11 = clip32(t3 - t2);
		acc = qmul(h00, y1);
		acc = clip32(acc + qmul(qmul(h10, h), s1));
		acc = clip32(acc + qmul(h01, y2));
		acc = clip32(acc + qmul(qmul(h11, h), s2));
		return acc;
	endfunction

	function automatic force_t wall_force(pair_t it);
		force_t res;
		longint ex, ey, r, s, nom, smax, lft, rgt, deff, f, f1, p;
		ex = longint'(it.ex);
		ey = longint'(it.ey);
		r = longint'(it.r);
		s = clip32(qmul(nu_q, longint'(it.v0)) + longint'(it.vn));
		nom = qmul(qmul(s, s), longint'(it.k));
		smax = clip32(32768 - width_q);
		lft = clip32(32768 + width_q);
		rgt = clip32(cut_q - width_q);
		deff = clip32(longint'(it.d) - r);
		if (deff >= cut_q) begin
			res.fx = '0;
			res.fy = '0;
			res.zone = ZONE_NONE;
		end else if (deff <= clip32(smax + r)) begin
			res.fx = fx_t'(qmul(ex, -fmax_q));
			res.fy = fx_t'(qmul(ey, -fmax_q));
			res.zone = ZONE_CLAMP;
		end else begin
			if (deff > rgt) begin
				f = clip32(-qdiv(nom, rgt));
				f1 = clip32(-qdiv(f, rgt));
				p = spline(deff, rgt, cut_q, f, 0, f1, 0);
				res.zone = ZONE_TAPER;
			end else if (deff >= lft) begin
				p = clip32(-qdiv(nom, deff < 0 ? clip32(-deff) : deff));
				res.zone = ZONE_INVERSE;
			end else begin
				f = clip32(-qdiv(nom, lft));
				f1 = clip32(-qdiv(f, lft));
				p = spline(deff, smax, lft, qmul(fmax_q, f), f, 0, f1);
				res.zone = ZONE_BLEND;
			end
			res.fx = fx_t'(qmul(ex, p));
			res.fy = fx_t'(qmul(ey, p));
		end
		return res;
	endfunction

	task automatic report(string what, int unsigned got, int unsigned want);
		$display("mismatch %s at result %0d: got %h expected %h", what, n_out, got, want);
		errors++;
	endtask

	task automatic add_pair(int v0, int k, int ex, int ey, fx_t vn, int d, int r);
		pair_t it;
		it.v0 = 31'(v0);
		it.k = 31'(k);
		it.ex = dir_t'(ex);
		it.ey = dir_t'(ey);
		it.vn = vn;
		it.d = 31'(d);
		it.r = 31'(r);
		pending.insert(pending.size(), it);
	endtask

	task automatic add_random_pair();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 2)
			add_pair($urandom, $urandom, $urandom_range(0, 131072) - 65536,
				$urandom_range(0, 131072) - 65536, $urandom, $urandom, $urandom);
		else if (kind < 4)
			add_pair($urandom_range(0, 131072), $urandom_range(0, 131072),
				$urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
				$urandom_range(0, 262144) - 131072, $urandom_range(0, 196608),
				$urandom_range(0, 13107));
		else
			add_pair($urandom_range(0, 131072), $urandom_range(0, 131072),
				$urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
				$urandom_range(0, 262144) - 131072, $urandom_range(0, 262144),
				$urandom_range(0, 65536));
	endtask

	task automatic wait_drained();
		while (pending.size() != 0 || expected_forces.size() != 0) @(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [30:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_NU_GAIN: nu_q = value;
			REG_INTERP_WIDTH: width_q = value;
			REG_CUTOFF: cut_q = value;
			REG_MAX_FORCE: fmax_q = value;
		endcase
		n_cfg++;
	endtask

	task automatic set_regs(int nu, int w, int cut, int fmax);
		reg_write(REG_NU_GAIN, 31'(nu));
		reg_write(REG_INTERP_WIDTH, 31'(w));
		reg_write(REG_CUTOFF, 31'(cut));
		reg_write(REG_MAX_FORCE, 31'(fmax));
	endtask

	task automatic random_phase();
		repeat (PHASE_ITEMS) add_random_pair();
		wait_drained();
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_forces.insert(expected_forces.size(), wall_force(pending.pop_front()));
				n_in++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {pending[0].r, pending[0].d, pending[0].vn, pending[0].ey,
						pending[0].ex, pending[0].k, pending[0].v0};
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && n_in >= 40 && pending.size() >= 100) begin
				long_hold_done = 1'b1;
				hold_left = 400;
				m_tready <= 1'b0;
			end else if (n_out % 128 < 64) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= $urandom_range(0, 3) != 0;
			end
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_forces.size() == 0) begin
				report("unexpected transfer", m_tdata[31:0], 0);
			end else begin
				force_t want;
				want = expected_forces.pop_front();
				if (m_tdata[31:0] !== want.fx) report("force_x", m_tdata[31:0], want.fx);
				if (m_tdata[63:32] !== want.fy) report("force_y", m_tdata[63:32], want.fy);
				if (m_tuser !== want.zone) report("zone", m_tuser, want.zone);
				if (want.zone <= ZONE_CLAMP) zone_seen[want.zone]++;
			end
			n_out++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding",
				expected_forces.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_NU_GAIN;
		cfg_data = '0;
		errors = 0;
		n_in = 0;
		n_out = 0;
		n_cfg = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		hold_left = 0;
		long_hold_done = 1'b0;
		nu_q = 18350;
		width_q = 6554;
		cut_q = 131072;
		fmax_q = 196608;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: one pair per zone and the boundaries between them
		add_pair(0, 0, 0, 0, 0, 0, 0);
		add_pair(65536, 65536, 65536, 0, 0, 200000, 0);
		add_pair(65536, 65536, 0, 65536, 0, 131072, 0);
		add_pair(65536, 65536, 46341, 46341, 0, 131071, 0);
		add_pair(65536, 65536, 46341, -46341, 0, 125000, 0);
		add_pair(65536, 65536, -65536, 0, 0, 124518, 0);
		add_pair(31'h7FFF_FFFF, 31'h7FFF_FFFF, 65536, 65536, 0, 65536, 0);
		add_pair(65536, 131072, 0, -65536, 32768, 39322, 0);
		add_pair(65536, 131072, 65536, -65536, -32768, 39321, 0);
		add_pair(65536, 131072, 30000, 60000, 0, 30000, 0);
		add_pair(65536, 131072, 65536, 65536, 0, 26215, 0);
		add_pair(65536, 131072, -65536, 65536, 0, 26214, 0);
		add_pair(65536, 65536, 65536, 65536, 0, 0, 31'h7FFF_FFFF);
		add_pair(65536, 65536, -65536, -65536, 0, 31'h7FFF_FFFF, 0);
		add_pair(65536, 65536, 65536, 0, 32'sh8000_0000, 65536, 0);
		add_pair(65536, 65536, 0, 65536, 32'sh7FFF_FFFF, 65536, 0);
		add_pair(31'h7FFF_FFFF, 31'h7FFF_FFFF, 65536, -65536, 32'sh7FFF_FFFF, 30000, 0);
		add_pair(0, 31'h7FFF_FFFF, 65536, 65536, 0, 100000, 60000);
		add_pair(65536, 65536, 12345, -54321, 1000, 170000, 65536);
		add_pair(65536, 65536, 65536, 65536, 0, 13107, 13107);
		random_phase();

		set_regs('0, '0, '0, '0);
		random_phase();
		set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		random_phase();
		set_regs(30000, 0, 65536, 65536);
		random_phase();
		set_regs($urandom, $urandom, $urandom, $urandom);
		random_phase();
		set_regs($urandom_range(0, 65536), $urandom_range(0, 20000),
			$urandom_range(40000, 262144), $urandom_range(0, 500000));
		random_phase();
		set_regs(18350, 6554, 131072, 196608);
		random_phase();

		wait_drained();
		$display("%0d pairs in, %0d forces out, %0d register writes", n_in, n_out, n_cfg);
		$display("zones none/taper/inverse/blend/clamp: %0d/%0d/%0d/%0d/%0d",
			zone_seen[0], zone_seen[1], zone_seen[2], zone_seen[3], zone_seen[4]);
		if (errors == 0 && expected_forces.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
